### src/chep_pkg.sv
// Package for the core header entry parser: parse phases, result kinds,
// tag constants and the result record. No dependencies.
package chep_pkg;

  // Magic word "CORE" that opens every header page
  localparam logic [31:0] MAGIC_WORD    = 32'h434F_5245;

  // Entry tags
  localparam logic [31:0] TAG_END       = 32'd3840;
  localparam logic [31:0] TAG_DIRECTORY = 32'd3841;
  localparam logic [31:0] TAG_VALIDATE  = 32'd3845;
  localparam logic [31:0] TAG_VERSION   = 32'd3860;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_TAG  = 3'd1,
    PH_LEN  = 3'd2,
    PH_BODY = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_VALIDATE  = 3'd0,
    KIND_MAP       = 3'd1,
    KIND_MISMATCH  = 3'd2,
    KIND_UNKNOWN   = 3'd3,
    KIND_BAD_MAGIC = 3'd4,
    KIND_END       = 3'd5,
    KIND_MALFORMED = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [43:0] byte_address;
    logic [43:0] byte_length;
    logic [44:0] file_offset;
    logic [31:0] found_value;
  } result_t;

endpackage

### src/core_header_entry_parser_unit.sv
// Core header entry parser: walks a header page one word per transfer.
// Depends on chep_pkg.
//
// Each result is registered in the output register or the skid register.
// Throughput: one header word per cycle; the parser state updates in one pass.
// An output register plus a skid register let words keep flowing while a
// result waits; the input stalls only when both hold results.
// Reset (rst, synchronous, active high): parser waits for the magic word,
// expected_version clears to zero, both result registers are emptied.
module core_header_entry_parser_unit
  import chep_pkg::*;
#(
  parameter int PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,

  input  logic        item_valid,
  output logic        item_ready,
  input  logic        start_of_page,
  input  logic [31:0] header_word,

  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  kind,
  output logic [43:0] byte_address,
  output logic [43:0] byte_length,
  output logic [44:0] file_offset,
  output logic [31:0] found_value
);

  localparam int PAGE_WORDS = PAGE_BYTES / 4;
  localparam int POS_W      = $clog2(PAGE_WORDS) + 1;

  // Parser state
  phase_t             phase, phase_next;
  logic [31:0]        entry_tag, entry_tag_next;
  logic [POS_W-1:0]   body_words_left, body_words_left_next;
  logic [POS_W-1:0]   page_position, page_position_next;
  logic [1:0]         record_slot, record_slot_next;
  logic [31:0]        held_first, held_first_next;
  logic [31:0]        held_second, held_second_next;
  logic [31:0]        expected_version;

  // Result registers
  result_t            out_res, skid_res, new_res;
  logic               skid_valid;
  logic               new_hit;

  logic               item_accept, result_pop;
  logic               restart, magic_ok, tag_late, len_bad, tag_known;
  logic [31:0]        room, body_len;
  logic [31:0]        addr_pages;
  logic [63:0]        addr_prod, len_prod, off_prod;

  assign item_ready  = !skid_valid;
  assign item_accept = item_valid && item_ready;
  assign result_pop  = result_valid && result_ready;

  // Decode of the current word against the parser state
  assign restart   = start_of_page || (phase == PH_WAIT);
  assign magic_ok  = (header_word == MAGIC_WORD);
  assign tag_late  = (page_position >= POS_W'(PAGE_WORDS - 1));
  assign room      = 32'(PAGE_WORDS - 1) - 32'(page_position);
  assign body_len  = header_word - 32'd2;
  assign len_bad   = (header_word < 32'd2) || (body_len > room);
  assign tag_known = (entry_tag == TAG_DIRECTORY) || (entry_tag == TAG_VALIDATE) ||
                     (entry_tag == TAG_VERSION);

  // Page-to-byte scaling by the constant page size
  assign addr_pages = (entry_tag == TAG_VALIDATE) ? held_first : held_second;
  assign addr_prod  = 64'(addr_pages) * 64'(PAGE_BYTES);
  assign len_prod   = 64'(header_word) * 64'(PAGE_BYTES);
  assign off_prod   = (64'(held_first) + 64'd1) * 64'(PAGE_BYTES);

  // Next parser state
  always_comb begin
    phase_next           = phase;
    entry_tag_next       = entry_tag;
    body_words_left_next = body_words_left;
    page_position_next   = page_position;
    record_slot_next     = record_slot;
    held_first_next      = held_first;
    held_second_next     = held_second;
    if (item_accept) begin
      if (restart) begin
        entry_tag_next       = '0;
        body_words_left_next = '0;
        record_slot_next     = '0;
        held_first_next      = '0;
        held_second_next     = '0;
        page_position_next   = POS_W'(1);
        phase_next           = magic_ok ? PH_TAG : PH_DONE;
      end else begin
        unique case (phase)
          PH_TAG: begin
            if (tag_late) begin
              phase_next = PH_DONE;
            end else begin
              entry_tag_next     = header_word;
              phase_next         = PH_LEN;
              page_position_next = page_position + POS_W'(1);
            end
          end
          PH_LEN: begin
            page_position_next = page_position + POS_W'(1);
            if (entry_tag == TAG_END || len_bad) begin
              phase_next = PH_DONE;
            end else begin
              body_words_left_next = body_len[POS_W-1:0];
              record_slot_next     = '0;
              phase_next           = (body_len != 32'd0) ? PH_BODY : PH_TAG;
            end
          end
          PH_BODY: begin
            if (entry_tag == TAG_VERSION) begin
              if (record_slot == 2'd0) record_slot_next = 2'd1;
            end else if (entry_tag == TAG_VALIDATE) begin
              if (record_slot == 2'd0) begin
                held_first_next  = header_word;
                record_slot_next = 2'd1;
              end else begin
                record_slot_next = 2'd0;
              end
            end else if (entry_tag == TAG_DIRECTORY) begin
              priority case (record_slot)
                2'd0: begin
                  held_first_next  = header_word;
                  record_slot_next = 2'd1;
                end
                2'd1: begin
                  held_second_next = header_word;
                  record_slot_next = 2'd2;
                end
                default: record_slot_next = 2'd0;
              endcase
            end
            page_position_next   = page_position + POS_W'(1);
            body_words_left_next = body_words_left - POS_W'(1);
            if (body_words_left <= POS_W'(1)) phase_next = PH_TAG;
          end
          default: ;
        endcase
      end
    end
  end

  // Result produced by the current word
  always_comb begin
    new_res = '0;
    new_hit = 1'b0;
    if (item_accept) begin
      if (restart) begin
        if (!magic_ok) begin
          new_hit             = 1'b1;
          new_res.kind        = KIND_BAD_MAGIC;
          new_res.found_value = header_word;
        end
      end else begin
        unique case (phase)
          PH_TAG: begin
            if (tag_late) begin
              new_hit             = 1'b1;
              new_res.kind        = KIND_MALFORMED;
              new_res.found_value = header_word;
            end
          end
          PH_LEN: begin
            if (entry_tag == TAG_END) begin
              new_hit      = 1'b1;
              new_res.kind = KIND_END;
            end else if (len_bad) begin
              new_hit             = 1'b1;
              new_res.kind        = KIND_MALFORMED;
              new_res.found_value = header_word;
            end else if (!tag_known) begin
              new_hit             = 1'b1;
              new_res.kind        = KIND_UNKNOWN;
              new_res.found_value = entry_tag;
            end
          end
          PH_BODY: begin
            if (entry_tag == TAG_VERSION) begin
              if (record_slot == 2'd0 && header_word != expected_version) begin
                new_hit             = 1'b1;
                new_res.kind        = KIND_MISMATCH;
                new_res.found_value = header_word;
              end
            end else if (entry_tag == TAG_VALIDATE) begin
              if (record_slot != 2'd0) begin
                new_hit              = 1'b1;
                new_res.kind         = KIND_VALIDATE;
                new_res.byte_address = addr_prod[43:0];
                new_res.byte_length  = len_prod[43:0];
              end
            end else if (entry_tag == TAG_DIRECTORY) begin
              if (record_slot[1] && header_word != 32'd0) begin
                new_hit              = 1'b1;
                new_res.kind         = KIND_MAP;
                new_res.byte_address = addr_prod[43:0];
                new_res.byte_length  = len_prod[43:0];
                new_res.file_offset  = off_prod[44:0];
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Parser state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_WAIT;
      entry_tag        <= '0;
      body_words_left  <= '0;
      page_position    <= '0;
      record_slot      <= '0;
      held_first       <= '0;
      held_second      <= '0;
      expected_version <= '0;
    end else begin
      phase           <= phase_next;
      entry_tag       <= entry_tag_next;
      body_words_left <= body_words_left_next;
      page_position   <= page_position_next;
      record_slot     <= record_slot_next;
      held_first      <= held_first_next;
      held_second     <= held_second_next;
      if (cfg_write_en) expected_version <= cfg_write_data;
    end
  end

  // Output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_pop) begin
        skid_valid <= 1'b0;
      end
    end else if (new_hit && result_valid && !result_pop) begin
      skid_valid <= 1'b1;
    end else if (new_hit) begin
      result_valid <= 1'b1;
    end else if (result_pop) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result_pop) out_res <= skid_res;
    end else if (new_hit) begin
      if (result_valid && !result_pop) skid_res <= new_res;
      else out_res <= new_res;
    end
  end

  assign kind         = out_res.kind;
  assign byte_address = out_res.byte_address;
  assign byte_length  = out_res.byte_length;
  assign file_offset  = out_res.file_offset;
  assign found_value  = out_res.found_value;

`ifndef SYNTHESIS
  // Skid register only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds a result while output register is empty");

  // Body phase always has words still to consume
  a_body_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (body_words_left != '0))
    else $error("body phase with no words left");

  // Any accepted word leaves the parser out of the waiting phase
  a_leave_wait: assert property (@(posedge clk) disable iff (rst)
    item_accept |=> (phase != PH_WAIT))
    else $error("parser still waiting after a word transfer");

  // Position never runs past the page
  a_pos_in_page: assert property (@(posedge clk) disable iff (rst)
    page_position <= POS_W'(PAGE_WORDS))
    else $error("page position beyond page end");
`endif

endmodule
